### rtl/vtpy_pkg.sv
// package: widths, constants and the arctangent table function for the pitch/yaw core
`default_nettype none
package vtpy_pkg;

	localparam int COMPONENT_WIDTH     = 32;
	localparam int ANGLE_FRACTION_BITS = 16;

	localparam int GUARD_BITS  = 8;
	localparam int ACC_FRAC    = ANGLE_FRACTION_BITS + GUARD_BITS;
	localparam int N_ITER      = ANGLE_FRACTION_BITS + 10;
	localparam int SCALE_SHIFT = 60 - COMPONENT_WIDTH;
	localparam int DW          = 64;
	localparam int ACC_W       = ACC_FRAC + 12;
	localparam int RND_W       = ACC_W - GUARD_BITS;
	localparam int OUT_W       = 9 + ANGLE_FRACTION_BITS;

	localparam int S_TDATA_W = ((3 * COMPONENT_WIDTH + 7) / 8) * 8;
	localparam int M_TDATA_W = ((2 * OUT_W + 7) / 8) * 8;

	localparam logic [63:0] PI_Q60       = 64'h3243F6A8885A308D;
	localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;

	localparam logic signed [ACC_W-1:0] ACC_180 = ACC_W'(180) <<< ACC_FRAC;
	localparam logic [OUT_W:0] FULL_TURN = (OUT_W + 1)'(360) << ANGLE_FRACTION_BITS;
	localparam logic [OUT_W-1:0] DEG_90  = OUT_W'(90) << ANGLE_FRACTION_BITS;
	localparam logic [OUT_W-1:0] DEG_270 = OUT_W'(270) << ANGLE_FRACTION_BITS;

	// atan(2^-i) in degrees, Q(ACC_FRAC), from a Q56 series and a long division by pi
	function automatic logic signed [ACC_W-1:0] atan_entry(input int i);
		logic [63:0] sum;
		logic [63:0] term;
		logic [63:0] rem;
		logic [63:0] a;
		logic [63:0] q;
		logic [63:0] r;
		int e;
		int d;
		sum = '0;
		if (i == 0) begin
			return ACC_W'(45) <<< ACC_FRAC;
		end
		for (int k = 0; k < 60; k++) begin
			e = 56 - i * (2 * k + 1);
			if (e >= 0) begin
				d = 2 * k + 1;
				rem = '0;
				term = '0;
				for (int b = 56; b >= 0; b--) begin
					rem = (rem << 1) | ((b == e) ? 64'd1 : 64'd0);
					term = term << 1;
					if (rem >= 64'(d)) begin
						rem = rem - 64'(d);
						term = term | 64'd1;
					end
				end
				if (k % 2 == 1) sum = sum - term;
				else sum = sum + term;
			end
		end
		a = sum * 64'd45;
		q = '0;
		r = a;
		if (r >= PI_Q60) begin
			r = r - PI_Q60;
			q = 64'd1;
		end
		for (int k = 0; k < ACC_FRAC + 6; k++) begin
			r = r << 1;
			q = q << 1;
			if (r >= PI_Q60) begin
				r = r - PI_Q60;
				q = q | 64'd1;
			end
		end
		return q[ACC_W-1:0];
	endfunction

endpackage
`default_nettype wire

### rtl/vector_to_pitch_yaw_core.sv
// top level: direction vector to pitch and yaw through two pipelined cordic vectoring passes
//
//  channel   dir     handshake           payload
//  s_axis    in      s_tvalid/s_tready   s_tdata = dir_x, dir_y, dir_z (32 bits each)
//  m_axis    out     m_tvalid/m_tready   m_tdata = pitch_deg, yaw_deg (25 bits each), zero pad
//
//  one request per cycle while the output is not stalled; stages: entry stage, 26 yaw iterations, two
//  magnitude-scaling stages (the 1/K multiply), 26 pitch iterations, two finishing stages
//  the whole pipe moves on one enable: it holds while the output is full and not taken
//  arst_n clears every valid bit; data registers are not reset
//  no request is lost or repeated under stalls on either side
`default_nettype none
module vector_to_pitch_yaw_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// dir_x, dir_y, dir_z
	input  wire logic [vtpy_pkg::S_TDATA_W-1:0]    s_tdata,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// pitch_deg, yaw_deg, zero pad
	output logic [vtpy_pkg::M_TDATA_W-1:0]         m_tdata
);
	import vtpy_pkg::*;

	localparam int CW = COMPONENT_WIDTH;

	// global advance: the pipe moves when the output slot is free or being taken
	logic en;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	// input fields
	logic [CW-1:0] in_x, in_y, in_z;
	assign in_x = s_tdata[CW-1:0];
	assign in_y = s_tdata[2*CW-1:CW];
	assign in_z = s_tdata[3*CW-1:2*CW];

	logic signed [DW-1:0] ex, ey, ez;
	assign ex = DW'($signed(in_x));
	assign ey = DW'($signed(in_y));
	assign ez = DW'($signed(in_z));

	// pass 1 arrays: index 0 is the entry stage, index i+1 follows iteration i
	logic                    p1_v_s  [0:N_ITER];
	logic signed [DW-1:0]    p1_x_s  [0:N_ITER];
	logic signed [DW-1:0]    p1_y_s  [0:N_ITER];
	logic signed [ACC_W-1:0] p1_a_s  [0:N_ITER];
	logic signed [DW-1:0]    p1_nz_s [0:N_ITER];
	logic                    p1_zh_s [0:N_ITER];
	logic                    p1_zp_s [0:N_ITER];

	// entry stage: fold left half-plane, scale up, flag the vertical case
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) p1_v_s[0] <= 1'b0;
		else if (en) p1_v_s[0] <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ex[DW-1]) begin
				p1_x_s[0] <= (-ex) <<< SCALE_SHIFT;
				p1_y_s[0] <= (-ey) <<< SCALE_SHIFT;
				p1_a_s[0] <= ACC_180;
			end else begin
				p1_x_s[0] <= ex <<< SCALE_SHIFT;
				p1_y_s[0] <= ey <<< SCALE_SHIFT;
				p1_a_s[0] <= '0;
			end
			p1_nz_s[0] <= (-ez) <<< SCALE_SHIFT;
			p1_zh_s[0] <= (in_x == '0) && (in_y == '0);
			p1_zp_s[0] <= !in_z[CW-1] && (in_z != '0);
		end
	end

	// yaw pass: one rotation per stage
	for (genvar i = 0; i < N_ITER; i++) begin : g_p1
		localparam logic signed [ACC_W-1:0] T = atan_entry(i);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) p1_v_s[i+1] <= 1'b0;
			else if (en) p1_v_s[i+1] <= p1_v_s[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!p1_y_s[i][DW-1]) begin
					p1_x_s[i+1] <= p1_x_s[i] + (p1_y_s[i] >>> i);
					p1_y_s[i+1] <= p1_y_s[i] - (p1_x_s[i] >>> i);
					p1_a_s[i+1] <= p1_a_s[i] + T;
				end else begin
					p1_x_s[i+1] <= p1_x_s[i] - (p1_y_s[i] >>> i);
					p1_y_s[i+1] <= p1_y_s[i] + (p1_x_s[i] >>> i);
					p1_a_s[i+1] <= p1_a_s[i] - T;
				end
				p1_nz_s[i+1] <= p1_nz_s[i];
				p1_zh_s[i+1] <= p1_zh_s[i];
				p1_zp_s[i+1] <= p1_zp_s[i];
			end
		end
	end

	// gain correction, first half: two 32x32 partial products of the magnitude
	logic                    mul_v_s1;
	logic [63:0]             mul_hi_s1, mul_lo_s1;
	logic signed [ACC_W-1:0] mul_yaw_s1;
	logic signed [DW-1:0]    mul_nz_s1;
	logic                    mul_zh_s1, mul_zp_s1;
	logic [63:0]             mag;
	assign mag = p1_x_s[N_ITER];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mul_v_s1 <= 1'b0;
		else if (en) mul_v_s1 <= p1_v_s[N_ITER];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mul_hi_s1  <= 64'(mag[63:32]) * 64'(INV_GAIN_Q32);
			mul_lo_s1  <= 64'(mag[31:0]) * 64'(INV_GAIN_Q32);
			mul_yaw_s1 <= p1_a_s[N_ITER];
			mul_nz_s1  <= p1_nz_s[N_ITER];
			mul_zh_s1  <= p1_zh_s[N_ITER];
			mul_zp_s1  <= p1_zp_s[N_ITER];
		end
	end

	// pass 2 arrays; index 0 is the partial-product sum
	logic                    p2_v_s   [0:N_ITER];
	logic signed [DW-1:0]    p2_x_s   [0:N_ITER];
	logic signed [DW-1:0]    p2_y_s   [0:N_ITER];
	logic signed [ACC_W-1:0] p2_a_s   [0:N_ITER];
	logic signed [ACC_W-1:0] p2_yaw_s [0:N_ITER];
	logic                    p2_zh_s  [0:N_ITER];
	logic                    p2_zp_s  [0:N_ITER];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) p2_v_s[0] <= 1'b0;
		else if (en) p2_v_s[0] <= mul_v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p2_x_s[0]   <= $signed(mul_hi_s1 + {32'd0, mul_lo_s1[63:32]});
			p2_y_s[0]   <= mul_nz_s1;
			p2_a_s[0]   <= '0;
			p2_yaw_s[0] <= mul_yaw_s1;
			p2_zh_s[0]  <= mul_zh_s1;
			p2_zp_s[0]  <= mul_zp_s1;
		end
	end

	// pitch pass: one rotation per stage
	for (genvar i = 0; i < N_ITER; i++) begin : g_p2
		localparam logic signed [ACC_W-1:0] T = atan_entry(i);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) p2_v_s[i+1] <= 1'b0;
			else if (en) p2_v_s[i+1] <= p2_v_s[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!p2_y_s[i][DW-1]) begin
					p2_x_s[i+1] <= p2_x_s[i] + (p2_y_s[i] >>> i);
					p2_y_s[i+1] <= p2_y_s[i] - (p2_x_s[i] >>> i);
					p2_a_s[i+1] <= p2_a_s[i] + T;
				end else begin
					p2_x_s[i+1] <= p2_x_s[i] - (p2_y_s[i] >>> i);
					p2_y_s[i+1] <= p2_y_s[i] + (p2_x_s[i] >>> i);
					p2_a_s[i+1] <= p2_a_s[i] - T;
				end
				p2_yaw_s[i+1] <= p2_yaw_s[i];
				p2_zh_s[i+1]  <= p2_zh_s[i];
				p2_zp_s[i+1]  <= p2_zp_s[i];
			end
		end
	end

	// finishing, first half: round half up to the output fraction, lift negatives by 360
	logic signed [ACC_W-1:0] pitch_rnd, yaw_rnd;
	logic signed [RND_W-1:0] pitch_sh, yaw_sh;
	logic signed [RND_W-1:0] full_s;
	assign full_s    = RND_W'(FULL_TURN);
	assign pitch_rnd = p2_a_s[N_ITER] + ACC_W'(1 << (GUARD_BITS - 1));
	assign yaw_rnd   = p2_yaw_s[N_ITER] + ACC_W'(1 << (GUARD_BITS - 1));
	assign pitch_sh  = pitch_rnd[ACC_W-1:GUARD_BITS];
	assign yaw_sh    = yaw_rnd[ACC_W-1:GUARD_BITS];

	logic             fin_v_s1;
	logic [OUT_W:0]   fin_pitch_s1, fin_yaw_s1;
	logic             fin_zh_s1, fin_zp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fin_v_s1 <= 1'b0;
		else if (en) fin_v_s1 <= p2_v_s[N_ITER];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fin_pitch_s1 <= pitch_sh[RND_W-1] ? (OUT_W + 1)'(pitch_sh + full_s)
			                                  : (OUT_W + 1)'(pitch_sh);
			fin_yaw_s1   <= yaw_sh[RND_W-1] ? (OUT_W + 1)'(yaw_sh + full_s)
			                                : (OUT_W + 1)'(yaw_sh);
			fin_zh_s1    <= p2_zh_s[N_ITER];
			fin_zp_s1    <= p2_zp_s[N_ITER];
		end
	end

	// finishing, second half: fold 360 to 0, vertical vector override, output register
	logic [OUT_W:0]   pitch_w, yaw_w;
	logic [OUT_W-1:0] pitch_deg, yaw_deg;
	assign pitch_w = (fin_pitch_s1 >= FULL_TURN) ? fin_pitch_s1 - FULL_TURN : fin_pitch_s1;
	assign yaw_w   = (fin_yaw_s1 >= FULL_TURN) ? fin_yaw_s1 - FULL_TURN : fin_yaw_s1;

	always_comb begin
		if (fin_zh_s1) begin
			pitch_deg = fin_zp_s1 ? DEG_270 : DEG_90;
			yaw_deg   = '0;
		end else begin
			pitch_deg = pitch_w[OUT_W-1:0];
			yaw_deg   = yaw_w[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (en) m_tvalid <= fin_v_s1;
	end

	// pad bits above the two angles stay zero
	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= M_TDATA_W'({yaw_deg, pitch_deg});
		end
	end

endmodule
`default_nettype wire
